// File: rtl/sws_pkg.sv
// Shared types and constants for the sliding window statistics unit.
// No dependencies; imported by rtl/sliding_window_statistics_unit.sv.
`timescale 1ns / 1ps

package sws_pkg;

    // Default sizing
    localparam int MAX_WINDOW_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths
    localparam int WLEN_W    = 6;
    localparam int CNT_W     = 16;
    localparam int MEAN_W    = 24;
    localparam int STD_W     = 24;
    localparam int STATUS_W  = 2;
    localparam int MEAN_FRAC = 8;
    // deviation is Q.8, so the radicand carries twice that
    localparam int STD_SHIFT = 16;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_WINDOW_LENGTH = 1'b0,
        REG_SAMPLE_COUNT  = 1'b1
    } cfg_reg_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_TOO_LONG = 2'd1,
        STAT_WIN_ONE  = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GATHER,
        ST_MED0,
        ST_MED1,
        ST_MEAN_DIV,
        ST_MUL,
        ST_NUM,
        ST_STD_DIV,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_FINISH
    } state_t;

endpackage

// File: rtl/sliding_window_statistics_unit.sv
// Sliding window statistics unit: window store, gather pipeline, insertion
// sorter, shared restoring divider and digit-by-digit square root.
// Depends on rtl/sws_pkg.sv.
`timescale 1ns / 1ps

// Takes one signed sample per transaction and returns min, mean (Q.8), max,
// sample standard deviation (Q.8) and median (Q.1) of the trailing window of
// window_length samples. The unit works on one sample at a time and is not
// ready while it does. The shared restoring divider is D bits wide, where
// D = 2*SAMPLE_BITS + 2*clog2(MAX_WINDOW+1) + 16 (one quotient bit per cycle,
// used once for the mean and once for the variance), and the square root takes
// R = ceil(D/2) steps. A window that is too long for the data set skips the
// gather and the arithmetic. The window is read from the store one entry per
// cycle. A finished result waits in the output register while the next sample
// is accepted. No clearing pass is needed after reset.
module sliding_window_statistics_unit
    import sws_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [CNT_W-1:0]              cfg_data,
    // sample input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_value,
    // result output
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [CNT_W-1:0]              sample_index,
    output logic signed [SAMPLE_BITS-1:0] window_min,
    output logic signed [MEAN_W-1:0]      window_mean,
    output logic signed [SAMPLE_BITS-1:0] window_max,
    output logic [STD_W-1:0]              window_std_dev,
    output logic signed [SAMPLE_BITS:0]   window_median,
    output logic [STATUS_W-1:0]           status
);

    localparam int ADDR_W = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + LEN_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int SSQ_W  = SQ_W + LEN_W;
    localparam int NUM_W  = SSQ_W + LEN_W;
    localparam int DEN_W  = 2 * LEN_W;
    localparam int DIV_W  = NUM_W + STD_SHIFT;
    localparam int DCNT_W = $clog2(DIV_W + 1);
    localparam int RT_W   = (DIV_W + 1) / 2;
    localparam int RAD_W  = 2 * RT_W;
    localparam int RCNT_W = $clog2(RT_W + 1);
    localparam int MED_W  = SAMPLE_BITS + 1;

    // ---------------- registers ----------------
    state_t state_reg, state_next;

    logic [WLEN_W-1:0]       window_length_reg;
    logic [CNT_W-1:0]        sample_count_reg;
    logic [CNT_W-1:0]        pos_reg;
    logic [ADDR_W-1:0]       slot_reg;
    logic [MAX_WINDOW-1:0]   valid_bits_reg;
    logic signed [SAMPLE_BITS-1:0] first_reg;

    logic signed [SAMPLE_BITS-1:0] store_mem [MAX_WINDOW];

    logic                    bad_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [CNT_W-1:0]        index_reg;
    logic [LEN_W-1:0]        issue_cnt_reg;
    logic [LEN_W-1:0]        proc_cnt_reg;
    logic [ADDR_W-1:0]       rd_addr_reg;
    logic                    rd_v_reg;
    logic                    sq_v_reg;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic                    rd_hit_reg;

    logic signed [SAMPLE_BITS-1:0] min_reg, max_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [SSQ_W-1:0]        ssq_reg;
    logic signed [SAMPLE_BITS-1:0] lane_reg [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] lane_next [MAX_WINDOW];
    logic [ADDR_W-1:0]       med_idx_reg;
    logic signed [SAMPLE_BITS-1:0] med_a_reg;

    logic [NUM_W-1:0]        prod_a_reg, prod_b_reg;
    logic [DEN_W-1:0]        den_reg;

    logic [DIV_W-1:0]        div_quo_reg;
    logic [DEN_W-1:0]        div_rem_reg;
    logic [DEN_W-1:0]        div_den_reg;
    logic [DCNT_W-1:0]       div_cnt_reg;

    logic [RAD_W-1:0]        rt_rad_reg;
    logic [RT_W-1:0]         rt_root_reg;
    logic [RT_W+1:0]         rt_rem_reg;
    logic [RCNT_W-1:0]       rt_cnt_reg;

    logic signed [MEAN_W-1:0] mean_reg;
    logic [STD_W-1:0]        std_reg;
    logic signed [MED_W-1:0] med_reg;
    status_t                 status_reg;

    logic                    out_valid_reg;
    logic [CNT_W-1:0]        o_index_reg;
    logic signed [SAMPLE_BITS-1:0] o_min_reg, o_max_reg;
    logic signed [MEAN_W-1:0] o_mean_reg;
    logic [STD_W-1:0]        o_std_reg;
    logic signed [MED_W-1:0] o_med_reg;
    status_t                 o_status_reg;

    // ---------------- combinational ----------------
    logic                    accept;
    logic                    load_out;
    logic                    rd_en;
    logic                    gather_done;
    logic                    wl_bad;
    logic [CNT_W:0]          pos_plus;
    logic [ADDR_W-1:0]       slot_next;
    logic signed [SAMPLE_BITS-1:0] elem;
    logic signed [SQ_W-1:0]  elem_sq;
    logic [MAX_WINDOW-1:0]   lane_le;
    logic                    sum_neg;
    logic [SUM_W-1:0]        sum_mag;
    logic [MEAN_W-1:0]       mean_q;
    logic [DEN_W:0]          div_sh;
    logic                    div_ge;
    logic [RT_W+1:0]         rt_sh;
    logic [RT_W+1:0]         rt_trial;
    logic                    rt_ge;

    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    assign rd_en    = (state_reg == ST_GATHER) && (issue_cnt_reg < len_reg);
    assign gather_done = (issue_cnt_reg == len_reg) && !rd_v_reg && !sq_v_reg;

    assign wl_bad = (window_length_reg == '0)
                 || (int'(window_length_reg) > MAX_WINDOW)
                 || (CNT_W'(window_length_reg) > sample_count_reg);
    assign pos_plus  = {1'b0, pos_reg} + 1'b1;
    assign slot_next = (slot_reg == ADDR_W'(MAX_WINDOW - 1)) ? '0 : slot_reg + 1'b1;

    // window entry not written since the start of the set reads as its first sample
    assign elem    = rd_hit_reg ? rd_data_reg : first_reg;
    assign elem_sq = SQ_W'(elem) * SQ_W'(elem);

    assign sum_neg = sum_reg[SUM_W-1];
    assign sum_mag = sum_neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign mean_q  = MEAN_W'(div_quo_reg);

    // restoring divider step
    assign div_sh = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign div_ge = div_sh >= {1'b0, div_den_reg};

    // square root step, two radicand bits per cycle
    assign rt_sh    = {rt_rem_reg[RT_W-1:0], rt_rad_reg[RAD_W-1 -: 2]};
    assign rt_trial = {rt_root_reg, 2'b01};
    assign rt_ge    = rt_sh >= rt_trial;

    // insertion sorter: lanes at or past the fill count act as +infinity
    always_comb
    begin
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            lane_le[j] = (j < int'(proc_cnt_reg)) && (lane_reg[j] <= elem);
        end
        lane_next[0] = lane_le[0] ? lane_reg[0] : elem;
        for (int j = 1; j < MAX_WINDOW; j++)
        begin
            if (lane_le[j])
                lane_next[j] = lane_reg[j];
            else if (lane_le[j-1])
                lane_next[j] = elem;
            else
                lane_next[j] = lane_reg[j-1];
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (accept) state_next = ST_CHECK;
            ST_CHECK:     state_next = bad_reg ? ST_FINISH : ST_GATHER;
            ST_GATHER:    if (gather_done) state_next = ST_MED0;
            ST_MED0:      state_next = ST_MED1;
            ST_MED1:      state_next = ST_MEAN_DIV;
            ST_MEAN_DIV:
            begin
                if (div_cnt_reg == '0)
                    state_next = (len_reg == LEN_W'(1)) ? ST_FINISH : ST_MUL;
            end
            ST_MUL:       state_next = ST_NUM;
            ST_NUM:       state_next = ST_STD_DIV;
            ST_STD_DIV:   if (div_cnt_reg == '0) state_next = ST_SQRT_INIT;
            ST_SQRT_INIT: state_next = ST_SQRT;
            ST_SQRT:      if (rt_cnt_reg == '0) state_next = ST_FINISH;
            ST_FINISH:    if (load_out) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        cfg_ready = 1'b1;
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            window_length_reg <= WLEN_W'(4);
            sample_count_reg  <= {CNT_W{1'b1}};
            pos_reg           <= '0;
            slot_reg          <= '0;
            valid_bits_reg    <= '0;
            first_reg         <= '0;
            bad_reg           <= 1'b0;
            len_reg           <= '0;
            issue_cnt_reg     <= '0;
            proc_cnt_reg      <= '0;
            rd_v_reg          <= 1'b0;
            sq_v_reg          <= 1'b0;
            div_cnt_reg       <= '0;
            rt_cnt_reg        <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_WINDOW_LENGTH: window_length_reg <= cfg_data[WLEN_W-1:0];
                    REG_SAMPLE_COUNT:  sample_count_reg  <= cfg_data;
                    default:           sample_count_reg  <= cfg_data;
                endcase
            end

            // sample intake; a new set forgets which slots were written
            if (accept)
            begin
                if (pos_reg == '0)
                    first_reg <= sample_value;
                valid_bits_reg <= ((pos_reg == '0) ? '0 : valid_bits_reg)
                                | (MAX_WINDOW'(1) << slot_reg);
                slot_reg <= slot_next;
                pos_reg  <= (pos_plus >= {1'b0, sample_count_reg}) ? '0 : pos_plus[CNT_W-1:0];
                bad_reg  <= wl_bad;
                len_reg  <= LEN_W'(window_length_reg);
            end

            // gather pipeline
            if (state_reg == ST_CHECK)
            begin
                issue_cnt_reg <= '0;
                proc_cnt_reg  <= '0;
            end
            else
            begin
                if (rd_en)
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                if (rd_v_reg)
                    proc_cnt_reg <= proc_cnt_reg + 1'b1;
            end
            rd_v_reg <= rd_en;
            sq_v_reg <= rd_v_reg;

            // shared divider iteration count
            if (state_reg == ST_MED1 || state_reg == ST_NUM)
                div_cnt_reg <= DCNT_W'(DIV_W);
            else if ((state_reg == ST_MEAN_DIV || state_reg == ST_STD_DIV)
                     && div_cnt_reg != '0)
                div_cnt_reg <= div_cnt_reg - 1'b1;

            // square root iteration count
            if (state_reg == ST_SQRT_INIT)
                rt_cnt_reg <= RCNT_W'(RT_W);
            else if (state_reg == ST_SQRT && rt_cnt_reg != '0)
                rt_cnt_reg <= rt_cnt_reg - 1'b1;

            // output register
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- window store ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
            store_mem[slot_reg] <= sample_value;
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr_reg];
            rd_hit_reg  <= valid_bits_reg[rd_addr_reg];
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            index_reg   <= pos_reg;
            rd_addr_reg <= slot_reg;
        end

        // walk back through the window, newest first
        if (rd_en)
            rd_addr_reg <= (rd_addr_reg == '0) ? ADDR_W'(MAX_WINDOW - 1)
                                               : rd_addr_reg - 1'b1;

        if (state_reg == ST_CHECK)
        begin
            sum_reg     <= '0;
            ssq_reg     <= '0;
            med_idx_reg <= ADDR_W'((len_reg - 1'b1) >> 1);
            // too long: everything but the index reads zero
            min_reg     <= '0;
            max_reg     <= '0;
            mean_reg    <= '0;
            std_reg     <= '0;
            med_reg     <= '0;
            status_reg  <= STAT_TOO_LONG;
        end

        // per element: extremes, sum, square, sorted insert
        if (rd_v_reg)
        begin
            if (proc_cnt_reg == '0)
            begin
                min_reg <= elem;
                max_reg <= elem;
            end
            else
            begin
                if (elem < min_reg) min_reg <= elem;
                if (elem > max_reg) max_reg <= elem;
            end
            sum_reg  <= sum_reg + SUM_W'(elem);
            sq_reg   <= SQ_W'(elem_sq);
            lane_reg <= lane_next;
        end
        if (sq_v_reg)
            ssq_reg <= ssq_reg + SSQ_W'(sq_reg);

        // median: lower middle, then upper middle (same lane for odd windows)
        if (state_reg == ST_MED0)
        begin
            med_a_reg <= lane_reg[med_idx_reg];
            if (!len_reg[0])
                med_idx_reg <= med_idx_reg + 1'b1;
        end
        if (state_reg == ST_MED1)
        begin
            med_reg     <= MED_W'(med_a_reg) + MED_W'(lane_reg[med_idx_reg]);
            div_quo_reg <= DIV_W'(sum_mag) << MEAN_FRAC;
            div_rem_reg <= '0;
            div_den_reg <= DEN_W'(len_reg);
        end

        // shared divider
        if ((state_reg == ST_MEAN_DIV || state_reg == ST_STD_DIV) && div_cnt_reg != '0)
        begin
            div_rem_reg <= div_ge ? DEN_W'(div_sh - {1'b0, div_den_reg})
                                  : div_sh[DEN_W-1:0];
            div_quo_reg <= {div_quo_reg[DIV_W-2:0], div_ge};
        end

        // mean sign restore; window of one ends here
        if (state_reg == ST_MEAN_DIV && div_cnt_reg == '0)
        begin
            mean_reg   <= sum_neg ? -mean_q : mean_q;
            std_reg    <= '0;
            status_reg <= (len_reg == LEN_W'(1)) ? STAT_WIN_ONE : STAT_OK;
        end

        // variance numerator and denominator
        if (state_reg == ST_MUL)
        begin
            prod_a_reg <= NUM_W'(len_reg) * NUM_W'(ssq_reg);
            prod_b_reg <= NUM_W'(sum_mag) * NUM_W'(sum_mag);
            den_reg    <= DEN_W'(len_reg) * DEN_W'(len_reg - 1'b1);
        end
        if (state_reg == ST_NUM)
        begin
            div_quo_reg <= DIV_W'(prod_a_reg - prod_b_reg) << STD_SHIFT;
            div_rem_reg <= '0;
            div_den_reg <= den_reg;
        end

        // square root
        if (state_reg == ST_SQRT_INIT)
        begin
            rt_rad_reg  <= RAD_W'(div_quo_reg);
            rt_root_reg <= '0;
            rt_rem_reg  <= '0;
        end
        if (state_reg == ST_SQRT)
        begin
            if (rt_cnt_reg != '0)
            begin
                rt_rem_reg  <= rt_ge ? rt_sh - rt_trial : rt_sh;
                rt_root_reg <= {rt_root_reg[RT_W-2:0], rt_ge};
                rt_rad_reg  <= rt_rad_reg << 2;
            end
            else
            begin
                std_reg <= STD_W'(rt_root_reg);
            end
        end

        if (load_out)
        begin
            o_index_reg  <= index_reg;
            o_min_reg    <= min_reg;
            o_max_reg    <= max_reg;
            o_mean_reg   <= mean_reg;
            o_std_reg    <= std_reg;
            o_med_reg    <= med_reg;
            o_status_reg <= status_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sample_index   = o_index_reg;
    assign window_min     = o_min_reg;
    assign window_mean    = o_mean_reg;
    assign window_max     = o_max_reg;
    assign window_std_dev = o_std_reg;
    assign window_median  = o_med_reg;
    assign status         = o_status_reg;

    // ---------------- assertions ----------------
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("unit still ready after taking a sample");

    a_too_long_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_TOO_LONG |->
            window_min == '0 && window_max == '0 && window_mean == '0
            && window_std_dev == '0 && window_median == '0)
        else $error("too-long window with non-zero statistics");

    a_win_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_WIN_ONE |->
            window_std_dev == '0 && window_min == window_max)
        else $error("window of one with spread");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_TOO_LONG |->
            window_min <= window_max
            && window_median >= 2 * MED_W'(window_min)
            && window_median <= 2 * MED_W'(window_max))
        else $error("median or extremes out of order");

    a_gather_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GATHER |-> issue_cnt_reg <= len_reg)
        else $error("window read past its length");

endmodule
